FILE: sv/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// types, codes and constants shared by the i2c master status sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam int BUF_DEPTH = 256;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);

	localparam logic [7:0] MAX_ATT_RESET = 8'd3;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_ACK     = 3'd2,
		ACT_NACK    = 3'd3,
		ACT_RESTART = 3'd4,
		ACT_STOP    = 3'd5
	} act_t;

	// controller status codes
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_WADDR_ACK  = 8'h18;
	localparam logic [7:0] ST_WADDR_NACK = 8'h20;
	localparam logic [7:0] ST_WDATA_ACK  = 8'h28;
	localparam logic [7:0] ST_RADDR_ACK  = 8'h40;
	localparam logic [7:0] ST_RADDR_NACK = 8'h48;
	localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
	localparam logic [7:0] ST_RDATA_NACK = 8'h58;

	// classified operation handed from front to back
	typedef enum logic [3:0] {
		OP_LOAD,
		OP_START,
		OP_SHORT,
		OP_SENT,
		OP_WACK,
		OP_ANACK,
		OP_RXACK,
		OP_RADDR,
		OP_RXLAST,
		OP_OTHER
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       rd;
		logic [6:0] addr;
		logic [7:0] size;
		logic [7:0] lidx;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_count;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic [7:0] rx_index;
		logic       rx_valid;
		logic [7:0] tx_byte;
		logic       tx_valid;
		act_t       action;
	} res_t;

endpackage

FILE: sv/i2cms_ram.sv
// ----------------------------------------------------------------------------
// i2cms_ram
// single write port, single registered read port, old data on collision
// ----------------------------------------------------------------------------
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front
// input beat decode: sorts commands and status codes into operations
// ----------------------------------------------------------------------------
module i2cms_front import i2cms_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        q_full,
	output logic        push,
	output item_t       push_item
);

	cmd_t       cmd;
	logic [7:0] status;

	assign cmd    = cmd_t'(s_tuser);
	assign status = s_tdata[38:31];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		push_item.rd   = (cmd == CMD_READ);
		push_item.addr = s_tdata[6:0];
		push_item.size = s_tdata[14:7];
		push_item.lidx = s_tdata[22:15];
		push_item.data = s_tdata[30:23];
		push_item.op   = OP_OTHER;
		case (cmd)
			CMD_LOAD: begin
				push_item.op = OP_LOAD;
			end
			CMD_WRITE: begin
				push_item.op = OP_START;
			end
			CMD_READ: begin
				push_item.op = (s_tdata[14:7] < 8'd2) ? OP_SHORT : OP_START;
			end
			default: begin
				case (status)
					ST_START, ST_RESTART:         push_item.op = OP_SENT;
					ST_WADDR_ACK, ST_WDATA_ACK:   push_item.op = OP_WACK;
					ST_WADDR_NACK, ST_RADDR_NACK: push_item.op = OP_ANACK;
					ST_RDATA_ACK:                 push_item.op = OP_RXACK;
					ST_RADDR_ACK:                 push_item.op = OP_RADDR;
					ST_RDATA_NACK:                push_item.op = OP_RXLAST;
					default:                      push_item.op = OP_OTHER;
				endcase
			end
		endcase
	end

endmodule

FILE: sv/i2cms_queue.sv
// ----------------------------------------------------------------------------
// i2cms_queue
// two-entry queue of classified operations between front and back
// ----------------------------------------------------------------------------
module i2cms_queue import i2cms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  head_valid,
	output item_t head_item,
	input  logic  pop
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != 2'd0))
		else $error("queue underflow");

endmodule

FILE: sv/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back
// executes operations against the sequencer state and send buffer
// ----------------------------------------------------------------------------
module i2cms_back import i2cms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr,
	input  logic [7:0] cfg_data,
	input  logic       head_valid,
	input  item_t      head_item,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output res_t       res
);

	logic [7:0] pos_q, pos_d;
	logic [7:0] size_q, size_d;
	logic [7:0] retry_q, retry_d;
	logic [7:0] addr_q, addr_d;
	logic       busy_q, busy_d;
	logic [7:0] max_att_q;

	logic       out_valid_q;
	res_t       res_q;
	res_t       res_d;

	logic       exec;
	logic [7:0] pos_inc;
	logic [8:0] pos_nack;

	logic              wr_en;
	logic [BUF_AW-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [BUF_AW-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              byp_hit_q;
	logic [7:0]        byp_data_q;
	logic [7:0]        buf_byte;

	assign pop  = head_valid && (!out_valid_q || m_tready);
	assign exec = pop;

	// buffer byte at position + 1, read ahead from the next position
	assign buf_byte = byp_hit_q ? byp_data_q : rd_data;
	assign pos_inc  = pos_q + 8'd1;
	assign pos_nack = {1'b0, pos_inc} + 9'd1;

	always_comb begin
		pos_d   = pos_q;
		size_d  = size_q;
		retry_d = retry_q;
		addr_d  = addr_q;
		busy_d  = busy_q;
		wr_en   = 1'b0;
		wr_addr = head_item.lidx[BUF_AW-1:0];
		wr_data = head_item.data;
		res_d   = '0;
		res_d.action = ACT_NONE;
		if (exec) begin
			case (head_item.op)
				OP_LOAD: begin
					wr_en = 1'b1;
				end
				OP_START: begin
					if (!busy_q) begin
						size_d       = head_item.size;
						retry_d      = 8'd0;
						addr_d       = {head_item.addr, head_item.rd};
						busy_d       = 1'b1;
						pos_d        = 8'd0;
						res_d.action = ACT_START;
					end
				end
				OP_SHORT: begin
				end
				OP_SENT: begin
					res_d.tx_valid = 1'b1;
					res_d.tx_byte  = addr_q;
					res_d.action   = ACT_ACK;
				end
				OP_WACK: begin
					pos_d = pos_inc;
					if (pos_inc == size_q) begin
						res_d.action = ACT_STOP;
						busy_d       = 1'b0;
					end else begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = buf_byte;
						res_d.action   = ACT_ACK;
					end
				end
				OP_ANACK: begin
					if (retry_q < max_att_q) begin
						res_d.action = ACT_RESTART;
						retry_d      = retry_q + 8'd1;
					end else begin
						res_d.action = ACT_STOP;
						busy_d       = 1'b0;
					end
				end
				OP_RXACK, OP_RADDR: begin
					if (head_item.op == OP_RXACK) begin
						wr_en          = 1'b1;
						wr_addr        = pos_q[BUF_AW-1:0];
						res_d.rx_valid = 1'b1;
						res_d.rx_index = pos_q;
						res_d.rx_byte  = head_item.data;
					end
					pos_d        = pos_inc;
					res_d.action = (pos_nack == {1'b0, size_q}) ? ACT_NACK : ACT_ACK;
				end
				OP_RXLAST: begin
					wr_en          = 1'b1;
					wr_addr        = pos_q[BUF_AW-1:0];
					res_d.rx_valid = 1'b1;
					res_d.rx_index = pos_q;
					res_d.rx_byte  = head_item.data;
					pos_d          = pos_inc;
					res_d.action   = ACT_STOP;
					busy_d         = 1'b0;
				end
				default: begin
					res_d.action = ACT_STOP;
					busy_d       = 1'b0;
				end
			endcase
		end
		res_d.busy_res   = busy_d;
		res_d.byte_count = (head_item.op == OP_SHORT && !busy_q) ? 8'd0 : pos_d;
	end

	always_comb begin
		logic [7:0] next_inc;
		next_inc = pos_d + 8'd1;
		rd_addr  = next_inc[BUF_AW-1:0];
	end

	i2cms_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		byp_data_q <= wr_data;
		if (exec) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 8'd0;
			size_q      <= 8'd0;
			retry_q     <= 8'd0;
			addr_q      <= 8'd0;
			busy_q      <= 1'b0;
			max_att_q   <= MAX_ATT_RESET;
			out_valid_q <= 1'b0;
			byp_hit_q   <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			size_q    <= size_d;
			retry_q   <= retry_d;
			addr_q    <= addr_d;
			busy_q    <= busy_d;
			byp_hit_q <= wr_en && (wr_addr == rd_addr);
			if (cfg_wr) begin
				max_att_q <= cfg_data;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = res_q;

	a_busy_drop_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && busy_q && !busy_d) |-> (res_d.action == ACT_STOP))
		else $error("busy cleared without stop");

	a_start_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && res_d.action == ACT_START) |=> (busy_q && pos_q == 8'd0 && retry_q == 8'd0))
		else $error("start did not set up transfer");

	a_rx_written: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && res_d.rx_valid) |-> (wr_en && wr_addr == pos_q[BUF_AW-1:0]))
		else $error("received byte not stored");

	a_no_exec_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !exec)
		else $error("result overwritten while held");

endmodule

FILE: sv/i2c_master_status_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer
// sequences an i2c byte controller from buffer loads, starts and status codes
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: operands and status, tuser: command
//  m_*      out  m_tvalid/m_tready    tdata: action, tx, rx, busy, count
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data: max_attempts
//
//  one input beat per cycle sustained unless the output stalls; each beat gives one result beat
//  an input beat passes through the queue and the result reg before its result beat
//  the send buffer is read ahead at position plus one through a registered port, with bypass
//  a stalled output holds its result; the two-entry queue absorbs the input
//  reset clears the sequencer state; buffer contents are undefined until written
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer import i2cms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slave_address, transfer_size, load_index, data_byte, status_code, pad
	input  logic [39:0] s_tdata,
	// command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// action, tx_valid, tx_byte, rx_valid, rx_index, rx_byte, busy_res,
	// byte_count, pad
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  head_valid;
	item_t head_item;
	logic  pop;
	res_t  res;

	assign cfg_ready = 1'b1;

	i2cms_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item)
	);

	i2cms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop)
	);

	i2cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tdata = {2'b00, res.byte_count, res.busy_res, res.rx_byte, res.rx_index,
		res.rx_valid, res.tx_byte, res.tx_valid, res.action};

endmodule

FILE: tb/sv/i2c_master_status_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer_tb
// self-checking bench for the i2c master status sequencer: a behavioural
// shadow of the sequencer predicts each result beat from every accepted
// input beat, and a checker compares the output stream field by field.
// directed write, read, retry and idle cases come first, then back pressure,
// position wrap-around and random transfers under several retry limits,
// with random sender gaps outside the back pressure burst and receiver stalls throughout
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer_tb;
	import i2cms_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int unsigned RUN_LIMIT_NS = 5_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// slave_address, transfer_size, load_index, data_byte, status_code, pad
	logic [39:0] s_tdata   = '0;
	// command
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// action, tx_valid, tx_byte, rx_valid, rx_index, rx_byte, busy_res,
	// byte_count, pad
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	// shadow of the sequencer state
	logic [7:0] shadow_buf [BUF_DEPTH];
	bit         written    [BUF_DEPTH];
	logic [7:0] seq_pos      = '0;
	logic [7:0] seq_size     = '0;
	logic [7:0] seq_retries  = '0;
	logic [7:0] seq_addr     = '0;
	logic       seq_busy     = 1'b0;
	logic [7:0] seq_max_att  = MAX_ATT_RESET;

	res_t expected_results [$];
	res_t last_result;
	int   mismatch_count = 0;
	int   items_sent     = 0;
	int   burst_left     = 0;
	bit   gapless        = 1'b0;
	bit   hold_request   = 1'b0;

	logic [7:0] known_codes [9] = '{ST_START, ST_RESTART, ST_WADDR_ACK, ST_WADDR_NACK,
		ST_WDATA_ACK, ST_RADDR_ACK, ST_RADDR_NACK, ST_RDATA_ACK, ST_RDATA_NACK};

	i2c_master_status_sequencer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic res_t advance_sequencer(cmd_t cmd, logic [6:0] addr, logic [7:0] tsize,
		logic [7:0] lidx, logic [7:0] dbyte, logic [7:0] status);
		res_t r;
		logic short_read;
		r = '0;
		r.action = ACT_NONE;
		short_read = 1'b0;
		case (cmd)
		CMD_LOAD: begin
			shadow_buf[lidx] = dbyte;
			written[lidx] = 1'b1;
		end
		CMD_WRITE, CMD_READ: begin
			if (!seq_busy) begin
				if (cmd == CMD_READ && tsize < 8'd2) begin
					short_read = 1'b1;
				end else begin
					seq_size = tsize;
					seq_retries = '0;
					seq_addr = {addr, cmd == CMD_READ};
					seq_busy = 1'b1;
					seq_pos = '0;
					r.action = ACT_START;
				end
			end
		end
		default: begin
			case (status)
			ST_START, ST_RESTART: begin
				r.tx_valid = 1'b1;
				r.tx_byte = seq_addr;
				r.action = ACT_ACK;
			end
			ST_WADDR_ACK, ST_WDATA_ACK: begin
				seq_pos = seq_pos + 8'd1;
				if (seq_pos == seq_size) begin
					r.action = ACT_STOP;
					seq_busy = 1'b0;
				end else begin
					r.tx_valid = 1'b1;
					r.tx_byte = shadow_buf[seq_pos];
					r.action = ACT_ACK;
				end
			end
			ST_WADDR_NACK, ST_RADDR_NACK: begin
				if (seq_retries < seq_max_att) begin
					r.action = ACT_RESTART;
					seq_retries = seq_retries + 8'd1;
				end else begin
					r.action = ACT_STOP;
					seq_busy = 1'b0;
				end
			end
			ST_RDATA_ACK, ST_RADDR_ACK: begin
				if (status == ST_RDATA_ACK) begin
					shadow_buf[seq_pos] = dbyte;
					written[seq_pos] = 1'b1;
					r.rx_valid = 1'b1;
					r.rx_index = seq_pos;
					r.rx_byte = dbyte;
				end
				seq_pos = seq_pos + 8'd1;
				// no wrap on the look-ahead compare
				r.action = ({1'b0, seq_pos} + 9'd1 == {1'b0, seq_size}) ? ACT_NACK : ACT_ACK;
			end
			ST_RDATA_NACK: begin
				shadow_buf[seq_pos] = dbyte;
				written[seq_pos] = 1'b1;
				r.rx_valid = 1'b1;
				r.rx_index = seq_pos;
				r.rx_byte = dbyte;
				seq_pos = seq_pos + 8'd1;
				r.action = ACT_STOP;
				seq_busy = 1'b0;
			end
			default: begin
				r.action = ACT_STOP;
				seq_busy = 1'b0;
			end
			endcase
		end
		endcase
		r.busy_res = seq_busy;
		r.byte_count = short_read ? 8'd0 : seq_pos;
		return r;
	endfunction

	task automatic send_item(cmd_t cmd, logic [6:0] addr, logic [7:0] tsize, logic [7:0] lidx,
		logic [7:0] dbyte, logic [7:0] status);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, status, dbyte, lidx, tsize, addr};
		do @(posedge clk); while (!s_tready);
		last_result = advance_sequencer(cmd, addr, tsize, lidx, dbyte, status);
		expected_results.push_back(last_result);
		items_sent++;
		if (!gapless) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
				burst_left = $urandom_range(1, 24);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic load_byte(logic [7:0] idx, logic [7:0] d);
		send_item(CMD_LOAD, 7'($urandom), 8'($urandom), idx, d, 8'($urandom));
	endtask

	task automatic start_transfer(cmd_t cmd, logic [6:0] addr, logic [7:0] tsize);
		send_item(cmd, addr, tsize, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic status_event(logic [7:0] code, logic [7:0] d);
		logic [7:0] next_pos;
		next_pos = seq_pos + 8'd1;
		// never let the sequencer fetch a buffer byte that was never written
		if ((code == ST_WADDR_ACK || code == ST_WDATA_ACK) && next_pos != seq_size
			&& !written[next_pos])
			load_byte(next_pos, 8'($urandom));
		send_item(CMD_STATUS, 7'($urandom), 8'($urandom), 8'($urandom), d, code);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_attempts(logic [7:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seq_max_att = value;
	endtask

	task automatic test_write_transfer();
		load_byte(8'd1, 8'hFF);
		load_byte(8'd2, 8'h00);
		load_byte(8'd255, 8'hA5);
		load_byte(8'd0, 8'h5A);
		start_transfer(CMD_WRITE, 7'h7F, 8'd3);
		status_event(ST_START, 8'h00);
		status_event(ST_WADDR_ACK, 8'hFF);
		status_event(ST_WDATA_ACK, 8'h00);
		status_event(ST_WDATA_ACK, 8'hFF);
		start_transfer(CMD_WRITE, 7'h00, 8'd1);
		status_event(ST_START, 8'h00);
		status_event(ST_WADDR_ACK, 8'h00);
	endtask

	task automatic test_read_and_retries();
		start_transfer(CMD_READ, 7'h00, 8'd2);
		start_transfer(CMD_WRITE, 7'h55, 8'd9);
		status_event(ST_START, 8'h00);
		repeat (4) status_event(ST_RADDR_NACK, 8'h00);
		start_transfer(CMD_READ, 7'h2A, 8'd2);
		status_event(ST_WADDR_NACK, 8'h00);
		status_event(ST_RESTART, 8'h00);
		status_event(ST_RADDR_ACK, 8'h00);
		status_event(ST_RDATA_NACK, 8'hFF);
	endtask

	task automatic test_short_reads_and_idle_status();
		start_transfer(CMD_READ, 7'h7F, 8'd0);
		start_transfer(CMD_READ, 7'h7F, 8'd1);
		status_event(8'hFF, 8'hFF);
		status_event(8'h00, 8'h00);
		status_event(ST_WADDR_NACK, 8'h00);
		status_event(ST_RDATA_ACK, 8'h00);
	endtask

	task automatic test_back_pressure();
		settle();
		gapless = 1'b1;
		hold_request = 1'b1;
		repeat (24) load_byte(8'($urandom), 8'($urandom));
		gapless = 1'b0;
		settle();
	endtask

	task automatic test_index_wrap();
		// a long read carries the position past 255 and fills the whole buffer
		start_transfer(CMD_READ, 7'($urandom), 8'd255);
		status_event(ST_START, 8'($urandom));
		status_event(ST_RADDR_ACK, 8'($urandom));
		repeat (300) status_event(ST_RDATA_ACK, 8'($urandom));
		status_event(ST_RDATA_NACK, 8'($urandom));
		// size zero writes until the position wraps back to zero
		start_transfer(CMD_WRITE, 7'($urandom), 8'd0);
		status_event(ST_START, 8'($urandom));
		status_event(ST_WADDR_ACK, 8'($urandom));
		while (seq_busy) status_event(ST_WDATA_ACK, 8'($urandom));
	endtask

	task automatic test_random_traffic();
		logic [7:0] limits [4];
		int quota [4];
		int target, kind, n, steps;
		cmd_t cmd;
		limits = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254))};
		quota = '{300, 300, 300, 400};
		for (int p = 0; p < 4; p++) begin
			set_max_attempts(limits[p]);
			target = items_sent + quota[p];
			while (items_sent < target) begin
				kind = $urandom_range(0, 99);
				if (kind < 40) begin
					n = ($urandom_range(0, 23) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
					if (n <= 8)
						for (int k = 1; k <= n; k++) load_byte(8'(k), 8'($urandom));
					start_transfer(CMD_WRITE, 7'($urandom), 8'(n + 1));
					status_event(ST_START, 8'($urandom));
					while (seq_busy && $urandom_range(0, 3) == 0) begin
						status_event(ST_WADDR_NACK, 8'($urandom));
						if (seq_busy) status_event(ST_RESTART, 8'($urandom));
					end
					if (seq_busy) status_event(ST_WADDR_ACK, 8'($urandom));
					steps = 0;
					while (seq_busy && steps < 300) begin
						status_event(($urandom_range(0, 40) == 0) ? 8'($urandom) : ST_WDATA_ACK,
							8'($urandom));
						steps++;
					end
				end else if (kind < 75) begin
					n = ($urandom_range(0, 23) == 0) ? $urandom_range(9, 255) : $urandom_range(2, 8);
					start_transfer(CMD_READ, 7'($urandom), 8'(n));
					status_event(ST_START, 8'($urandom));
					while (seq_busy && $urandom_range(0, 3) == 0) begin
						status_event(ST_RADDR_NACK, 8'($urandom));
						if (seq_busy) status_event(ST_RESTART, 8'($urandom));
					end
					if (seq_busy) status_event(ST_RADDR_ACK, 8'($urandom));
					steps = 0;
					while (seq_busy && steps < 300) begin
						if (last_result.action == ACT_NACK)
							status_event(ST_RDATA_NACK, 8'($urandom));
						else
							status_event(($urandom_range(0, 30) == 0) ? 8'($urandom) : ST_RDATA_ACK,
								8'($urandom));
						steps++;
					end
				end else if (kind < 90) begin
					cmd = cmd_t'($urandom_range(0, 3));
					if (cmd == CMD_STATUS)
						status_event(8'($urandom), 8'($urandom));
					else
						send_item(cmd, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
							8'($urandom));
				end else begin
					// broken sequence: a start followed by codes out of order
					start_transfer($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 7'($urandom),
						8'($urandom_range(0, 4)));
					repeat ($urandom_range(1, 5))
						status_event($urandom_range(0, 3) ? known_codes[$urandom_range(0, 8)]
							: 8'($urandom), 8'($urandom));
				end
			end
		end
	endtask

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		res_t got, want;
		if (m_tvalid && m_tready) begin
			got = res_t'(m_tdata[37:0]);
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$error("result beat with nothing expected: %h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				compare_field("action", want.action, got.action);
				compare_field("tx_valid", want.tx_valid, got.tx_valid);
				compare_field("tx_byte", want.tx_byte, got.tx_byte);
				compare_field("rx_valid", want.rx_valid, got.rx_valid);
				compare_field("rx_index", want.rx_index, got.rx_index);
				compare_field("rx_byte", want.rx_byte, got.rx_byte);
				compare_field("busy_res", want.busy_res, got.busy_res);
				compare_field("byte_count", want.byte_count, got.byte_count);
			end
		end
	end

	// receiver stalls: the ready mode is redrawn at random intervals
	initial begin
		int rdy_mode, mode_cycles;
		rdy_mode = 0;
		mode_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (mode_cycles == 0) begin
				rdy_mode = $urandom_range(0, 3);
				mode_cycles = $urandom_range(20, 200);
			end else begin
				mode_cycles--;
			end
			case (rdy_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (mode_cycles % 5) < 2;
			endcase
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		set_max_attempts(MAX_ATT_RESET);
		test_write_transfer();
		test_read_and_retries();
		test_short_reads_and_idle_status();
		test_back_pressure();
		test_index_wrap();
		test_random_traffic();
		settle();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
